>>> rtl/assert_macros.svh
// Assertion macros shared by the sparse polynomial adder RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define SPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle.
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Expression holds at every edge out of reset.
`define SPA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant failed");

`else

`define SPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define SPA_ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/spa_pkg.sv
// Types and constants of the sparse polynomial adder.
// Used by spa_cell and sparse_polynomial_adder; no dependencies.
package spa_pkg;

    localparam int COEFF_W = 16;
    localparam int SUM_W   = 17;
    localparam int EXP_W   = 8;

    // Codes of the kind field; the unused code means nothing and is ignored.
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_ADD    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COEFF_W-1:0] term_coeff;
        logic [EXP_W-1:0]          exp_x;
        logic [EXP_W-1:0]          exp_y;
        logic [EXP_W-1:0]          exp_z;
    } t_in;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_coeff;
        logic [EXP_W-1:0]        out_x;
        logic [EXP_W-1:0]        out_y;
        logic [EXP_W-1:0]        out_z;
        logic                    is_empty;
        logic                    last;
    } t_out;

    // One stored term.
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic [EXP_W-1:0]          ex;
        logic [EXP_W-1:0]          ey;
        logic [EXP_W-1:0]          ez;
    } t_term;

    // An A term travelling along the row of cells.
    typedef struct packed {
        logic                    vld;
        logic                    found;
        logic signed [SUM_W-1:0] coeff;
        logic [EXP_W-1:0]        ex;
        logic [EXP_W-1:0]        ey;
        logic [EXP_W-1:0]        ez;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_FLUSH,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

>>> rtl/sparse_polynomial_adder.sv
// Top level of the sparse polynomial adder: A term memory, row of B cells,
// sequencer and output register. Depends on spa_pkg, spa_cell, assert_macros.svh.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+------------------------------
//   command  | i_data (t_in)               | start high, busy low
//   result   | o_data (t_out)              | o_strobe for one cycle
//
// Load words may follow back to back; busy stays low. An add word keeps busy high
// until the run ends: A terms stream through the row of MAX_TERMS cells, one cell
// per cycle, then the B terms shift out of the row one per cycle.
// Reset clears the counts, the sequencer and the valid flags; table contents
// are not cleared. The receiver cannot stall; the final word leaves as busy falls.
`include "assert_macros.svh"

module sparse_polynomial_adder
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_data,
    output t_out o_data,
    output logic o_strobe
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_count_a;
    logic [CNT_W-1:0] r_count_b;
    logic [CNT_W-1:0] r_idx;

    t_term mem_a [MAX_TERMS];
    t_term r_rd;
    logic  r_rd_vld;

    t_out r_pend;
    logic r_pend_vld;
    t_out r_out;
    logic r_strobe;

    logic  accept;
    logic  load_a;
    logic  load_b;
    logic  go_add;
    logic  rd_en;
    logic  shift;
    logic  push;
    logic  fin;
    t_out  push_word;
    t_term load_term;

    t_slot w_slot [MAX_TERMS+1];
    t_term w_term [MAX_TERMS+1];
    logic [MAX_TERMS-1:0] w_vld;
    logic any_vld;

    assign accept = start && !busy;
    assign load_a = accept && (i_data.kind == KIND_LOAD_A) &&
                    (r_count_a < CNT_W'(MAX_TERMS));
    assign load_b = accept && (i_data.kind == KIND_LOAD_B) &&
                    (r_count_b < CNT_W'(MAX_TERMS));
    assign go_add = accept && (i_data.kind == KIND_ADD);

    assign load_term = '{coeff: i_data.term_coeff, ex: i_data.exp_x,
                         ey: i_data.exp_y, ez: i_data.exp_z};

    // ---------------------------------------------------------------
    // Sequencer: feed A terms, let the row empty, drain B, finish.
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (go_add) n_state = ST_FEED;
            end
            ST_FEED: begin
                if (r_idx == r_count_a) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_rd_vld && !any_vld) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_idx == r_count_b) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        rd_en     = 1'b0;
        shift     = 1'b0;
        push      = 1'b0;
        fin       = 1'b0;
        push_word = '{sum_coeff: w_slot[MAX_TERMS].coeff, out_x: w_slot[MAX_TERMS].ex,
                      out_y: w_slot[MAX_TERMS].ey, out_z: w_slot[MAX_TERMS].ez,
                      is_empty: 1'b0, last: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_FEED: begin
                rd_en = (r_idx != r_count_a);
                push  = w_slot[MAX_TERMS].vld;
            end
            ST_FLUSH: begin
                push = w_slot[MAX_TERMS].vld;
            end
            ST_DRAIN: begin
                // The head cell holds the oldest B term still to go; skip zeros.
                shift = (r_idx != r_count_b);
                push  = shift && (w_term[0].coeff != '0);
                push_word = '{sum_coeff: {w_term[0].coeff[COEFF_W-1], w_term[0].coeff},
                              out_x: w_term[0].ex, out_y: w_term[0].ey,
                              out_z: w_term[0].ez, is_empty: 1'b0, last: 1'b0};
            end
            ST_DONE: begin
                fin = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count_a <= '0;
            r_count_b <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (load_a) r_count_a <= r_count_a + 1'b1;
            if (load_b) r_count_b <= r_count_b + 1'b1;
            if (go_add) begin
                r_idx <= '0;
            end else if (rd_en || shift) begin
                r_idx <= r_idx + 1'b1;
            end else if (r_state == ST_FLUSH) begin
                r_idx <= '0;
            end
            // Empty both tables once the run is out.
            if (fin) begin
                r_count_a <= '0;
                r_count_b <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // A term memory: append on load, read in load order during feed.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (load_a) mem_a[r_count_a[IDX_W-1:0]] <= load_term;
        if (rd_en) r_rd <= mem_a[r_idx[IDX_W-1:0]];
    end

    assign w_slot[0] = '{vld: r_rd_vld, found: 1'b0,
                         coeff: {r_rd.coeff[COEFF_W-1], r_rd.coeff},
                         ex: r_rd.ex, ey: r_rd.ey, ez: r_rd.ez};
    assign w_term[MAX_TERMS] = '0;

    // ---------------------------------------------------------------
    // Row of cells: A terms move right one cell a cycle, each cell
    // holds one B term; B terms move left while draining.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < MAX_TERMS; j++) begin : g_cell
        spa_cell #(
            .INDEX (j),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (load_b),
            .i_count_b (r_count_b),
            .i_term    (load_term),
            .i_shift   (shift),
            .i_right   (w_term[j+1]),
            .i_slot    (w_slot[j]),
            .o_slot    (w_slot[j+1]),
            .o_term    (w_term[j])
        );
        assign w_vld[j] = w_slot[j+1].vld;
    end

    assign any_vld = |w_vld;

    // ---------------------------------------------------------------
    // Output: hold one word back so the final one can carry last.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else if (fin) begin
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b1;
        end else if (push) begin
            r_pend_vld <= 1'b1;
            r_strobe   <= r_pend_vld;
        end else begin
            r_strobe   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            if (r_pend_vld) begin
                r_out      <= r_pend;
                r_out.last <= 1'b1;
            end else begin
                r_out <= '{sum_coeff: '0, out_x: '0, out_y: '0, out_z: '0,
                           is_empty: 1'b1, last: 1'b1};
            end
        end else if (push) begin
            r_out  <= r_pend;
            r_pend <= push_word;
        end
    end

    assign o_data   = r_out;
    assign o_strobe = r_strobe;

    `SPA_ASSERT_NEXT(a_add_goes_busy, i_clk, i_rst_n, go_add, busy)
    `SPA_ASSERT_IMPLY(a_last_ends_run, i_clk, i_rst_n, o_strobe && o_data.last, !busy)
    `SPA_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n, o_strobe && o_data.is_empty, o_data.last)
    `SPA_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, (r_count_a <= CNT_W'(MAX_TERMS)) && (r_count_b <= CNT_W'(MAX_TERMS)))

endmodule

>>> rtl/spa_cell.sv
// One cell of the row: holds one B term and one travelling A term.
// Depends on spa_pkg.
module spa_cell
    import spa_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [CNT_W-1:0] i_count_b,
    input  t_term            i_term,
    input  logic             i_shift,
    input  t_term            i_right,
    input  t_slot            i_slot,
    output t_slot            o_slot,
    output t_term            o_term
);

    t_term r_b;
    t_slot r_slot;
    logic  r_vld;
    t_slot n_slot;
    logic  occupied;
    logic  hit;

    assign occupied = CNT_W'(INDEX) < i_count_b;
    assign hit = i_slot.vld && !i_slot.found && occupied &&
                 (i_slot.ex == r_b.ex) && (i_slot.ey == r_b.ey) && (i_slot.ez == r_b.ez);

    always_comb begin
        n_slot = i_slot;
        if (hit) begin
            n_slot.found = 1'b1;
            n_slot.coeff = i_slot.coeff + {r_b.coeff[COEFF_W-1], r_b.coeff};
        end
    end

    // Load on this cell's turn, shift towards the head while draining,
    // zero the coefficient once an A term has claimed it.
    always_ff @(posedge i_clk) begin
        if (i_load && (i_count_b == CNT_W'(INDEX))) begin
            r_b <= i_term;
        end else if (i_shift) begin
            r_b <= i_right;
        end else if (hit) begin
            r_b.coeff <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_slot.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_comb begin
        o_slot     = r_slot;
        o_slot.vld = r_vld;
    end

    assign o_term = r_b;

endmodule
